@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

@@ src/drq_pkg.sv @@
`default_nettype none

package drq_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH);
    localparam int KEY_W = 8;
    localparam int VAL_W = 32;
    localparam int OCC_W = 6;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_SUM  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_POP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_WALK   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        action_t                   action;
        logic [KEY_W-1:0]          entry_key;
        logic signed [VAL_W-1:0]   entry_value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [KEY_W-1:0]          result_key;
        logic signed [VAL_W-1:0]   result_value;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
    } stat_t;

endpackage

`default_nettype wire

@@ src/drq_ctrl.sv @@
`default_nettype none

module drq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire drq_pkg::stat_t stat,
    output drq_pkg::cmd_t      cmd,
    output logic               busy
);

    drq_pkg::state_t state_reg;
    drq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            drq_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = drq_pkg::S_WALK;
                end
            end
            drq_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = drq_pkg::S_FINISH;
                end
            end
            drq_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = drq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = drq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/drq_datapath.sv @@
`default_nettype none

module drq_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire drq_pkg::req_t request,
    input  wire drq_pkg::cmd_t cmd,
    output drq_pkg::stat_t     stat,
    output logic               done,
    output drq_pkg::rsp_t      result
);

    localparam int IW = drq_pkg::IDX_W;
    localparam int CW = drq_pkg::CNT_W;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        return (i == IW'(drq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [CW-1:0] ring_count(input logic [IW-1:0] h,
                                                 input logic [IW-1:0] t);
        logic [IW:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h)
        begin
            d = d + (IW+1)'(drq_pkg::DEPTH);
        end
        return CW'(d);
    endfunction

    // entry storage
    logic [drq_pkg::KEY_W-1:0] key_mem [drq_pkg::DEPTH];
    logic [drq_pkg::VAL_W-1:0] val_mem [drq_pkg::DEPTH];

    logic [IW-1:0]             head_reg, head_next;
    logic [IW-1:0]             tail_reg, tail_next;
    drq_pkg::req_t             op_reg, op_next;
    logic [IW-1:0]             walk_idx_reg, walk_idx_next;
    logic [CW-1:0]             issue_left_reg, issue_left_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [drq_pkg::KEY_W-1:0] rd_key_reg;
    logic [drq_pkg::VAL_W-1:0] rd_val_reg;
    logic [drq_pkg::KEY_W-1:0] key_cap_reg, key_cap_next;
    logic                      found_reg, found_next;
    logic [drq_pkg::VAL_W-1:0] acc_reg, acc_next;
    logic                      done_reg, done_next;
    drq_pkg::rsp_t             rsp_reg, rsp_next;

    logic [CW-1:0]             count;
    logic                      is_empty;
    logic                      is_full;
    logic                      push_ok;

    assign count    = ring_count(head_reg, tail_reg);
    assign is_empty = (head_reg == tail_reg);
    assign is_full  = (ring_next(tail_reg) == head_reg);
    assign push_ok  = cmd.finish && (op_reg.action == drq_pkg::ACT_PUSH)
                      && !found_reg && !is_full;

    assign stat.walk_done = (issue_left_reg == '0) && !rd_valid_reg;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        op_next         = op_reg;
        walk_idx_next   = walk_idx_reg;
        issue_left_next = issue_left_reg;
        rd_valid_next   = 1'b0;
        key_cap_next    = key_cap_reg;
        found_next      = found_reg;
        acc_next        = acc_reg;
        done_next       = cmd.finish;
        rsp_next        = rsp_reg;

        if (cmd.load)
        begin
            op_next       = request;
            walk_idx_next = head_reg;
            found_next    = 1'b0;
            acc_next      = '0;
            case (request.action) inside
                drq_pkg::ACT_PUSH, drq_pkg::ACT_SUM: issue_left_next = count;
                default: issue_left_next = is_empty ? '0 : CW'(1);
            endcase
        end

        if (cmd.walk)
        begin
            // issue one read a cycle, process the one issued last cycle
            if (issue_left_reg != '0)
            begin
                walk_idx_next   = ring_next(walk_idx_reg);
                issue_left_next = issue_left_reg - 1'b1;
                rd_valid_next   = 1'b1;
            end
            if (rd_valid_reg)
            begin
                found_next   = found_reg || (rd_key_reg == op_reg.entry_key);
                acc_next     = acc_reg + rd_val_reg;
                key_cap_next = rd_key_reg;
            end
        end

        if (cmd.finish)
        begin
            rsp_next.status       = drq_pkg::ST_DONE;
            rsp_next.result_key   = '0;
            rsp_next.result_value = '0;
            case (op_reg.action)
                drq_pkg::ACT_PUSH:
                begin
                    if (found_reg)
                    begin
                        rsp_next.status = drq_pkg::ST_DUP;
                    end
                    else if (is_full)
                    begin
                        rsp_next.status = drq_pkg::ST_FULL;
                    end
                    else
                    begin
                        tail_next = ring_next(tail_reg);
                    end
                end
                drq_pkg::ACT_SUM:
                begin
                    rsp_next.result_value = acc_reg;
                end
                default:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = drq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_key   = key_cap_reg;
                        rsp_next.result_value = acc_reg;
                        if (op_reg.action == drq_pkg::ACT_POP)
                        begin
                            head_next = ring_next(head_reg);
                        end
                    end
                end
            endcase
            rsp_next.occupancy = drq_pkg::OCC_W'(ring_count(head_next, tail_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            issue_left_reg <= '0;
            rd_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            issue_left_reg <= issue_left_next;
            rd_valid_reg   <= rd_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        walk_idx_reg <= walk_idx_next;
        key_cap_reg  <= key_cap_next;
        found_reg    <= found_next;
        acc_reg      <= acc_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            key_mem[tail_reg] <= op_reg.entry_key;
            val_mem[tail_reg] <= op_reg.entry_value;
        end
        rd_key_reg <= key_mem[walk_idx_reg];
        rd_val_reg <= val_mem[walk_idx_reg];
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire

@@ src/dedup_ring_queue_with_sum_unit.sv @@
`default_nettype none

// Ring queue of key/value entries with duplicate-key rejection and a value sum.
// Request channel: drive request (action, entry_key, entry_value) and raise start;
// the transaction is taken at a clock edge where start is high and busy is low.
// Busy stays high from the cycle after acceptance until the result is out.
// Result channel: done pulses for one cycle with result (status, result_key,
// result_value, occupancy); the receiver must take it then, it cannot stall.
// The walk covers every held entry for push and sum, and one entry for peek or
// pop on a non-empty queue; no stored entry is walked otherwise. The walk reads
// one entry a cycle from the single read port of the entry memory, and a full
// queue holds DEPTH-1 entries. A new transaction may be started in the same
// cycle that done is shown.
// Reset empties the queue (head and tail pointers cleared) and returns the
// controller to idle; the entry memory is not cleared and needs no sweep.
module dedup_ring_queue_with_sum_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire drq_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output drq_pkg::rsp_t      result
);

    drq_pkg::cmd_t  cmd;
    drq_pkg::stat_t stat;

    drq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    drq_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ src/drq_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module drq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire drq_pkg::rsp_t result
);

    logic accepted;
    logic occ_ok;
    logic is_empty_rsp;
    logic empty_zero;

    assign accepted     = start && !busy;
    assign occ_ok       = (result.occupancy <= drq_pkg::OCC_W'(drq_pkg::DEPTH - 1));
    assign is_empty_rsp = done && (result.status == drq_pkg::ST_EMPTY);
    assign empty_zero   = (result.result_key == '0) && (result.result_value == '0)
                          && (result.occupancy == '0);

    `ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accepted, busy && !done)
    `ASSERT_NOW(a_occ_bound, clk, rst_n, done, occ_ok)
    `ASSERT_NOW(a_empty_zero, clk, rst_n, is_empty_rsp, empty_zero)

endmodule

bind dedup_ring_queue_with_sum_unit drq_checker u_drq_checker (.*);

`default_nettype wire
